/* hdl/lis_pkg.sv */
// lis_pkg: shared constants, sequencer states and the count bank control bundle
// for the letter interleave scheduler; no dependencies
`default_nettype none

package lis_pkg;

  localparam int ALPHABET = 26;
  localparam int MAX_LEN  = 64;
  localparam int LET_W    = 5;
  localparam int CNT_W    = 7;
  localparam int LEN_W    = 7;

  localparam logic [LET_W-1:0] ALPHA_V   = LET_W'(ALPHABET);
  localparam logic [LET_W-1:0] LAST_CODE = LET_W'(ALPHABET - 1);
  localparam logic [LEN_W-1:0] MAX_LEN_V = LEN_W'(MAX_LEN);

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_SCAN,
    S_DECIDE,
    S_EMIT_A,
    S_EMIT_B,
    S_FAIL,
    S_CLEAR
  } lis_state_t;

  typedef struct packed {
    logic             clear;
    logic             inc_en;
    logic [LET_W-1:0] inc_idx;
    logic             dec_en;
    logic [LET_W-1:0] dec_idx;
    logic [LET_W-1:0] rd_idx;
  } lis_ctl_t;

endpackage

`default_nettype wire

/* hdl/lis_count_bank.sv */
// lis_count_bank: one count register per letter with increment, decrement,
// clear and a single scan read port; depends on lis_pkg
`default_nettype none

module lis_count_bank
  import lis_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lis_ctl_t         ctl,
  output logic      [CNT_W-1:0] rd_cnt
);

  logic [CNT_W-1:0] counts [ALPHABET];

  // per-letter counters, each entry decodes its own index
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ALPHABET; i++) begin
        counts[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ALPHABET; i++) begin
        if (ctl.clear) begin
          counts[i] <= '0;
        end else if (ctl.inc_en && ctl.inc_idx == LET_W'(i)) begin
          counts[i] <= counts[i] + CNT_W'(1);
        end else if (ctl.dec_en && ctl.dec_idx == LET_W'(i)) begin
          counts[i] <= counts[i] - CNT_W'(1);
        end
      end
    end
  end

  // scan read port
  assign rd_cnt = counts[ctl.rd_idx];

endmodule

`default_nettype wire

/* hdl/letter_interleave_scheduler.sv */
// letter_interleave_scheduler: top level with the load/scan/emit sequencer and
// output register; depends on lis_pkg and lis_count_bank
`default_nettype none

// Letters are taken at one beat per cycle and counted. The beat marked last
// starts the emit phase, during which in_stall stays high: each round walks
// all 26 counts through one shared compare unit, keeping the top two letters,
// then passes a decide state and emits each letter while the output register
// is free. A string that cannot be interleaved, or that is longer than 64
// letters, gives one failure beat instead of letters; an empty string gives
// no beats. Counts clear in the S_CLEAR state at the end of every string.
module letter_interleave_scheduler
  import lis_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [LET_W-1:0] letter,
  input  wire logic             last,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [LET_W-1:0] out_letter,
  output logic                  out_last,
  output logic                  failed
);

  lis_state_t       state, state_next;
  lis_ctl_t         ctl;
  logic [CNT_W-1:0] rd_cnt;

  logic [LET_W-1:0] idx;
  logic [LET_W-1:0] best_idx, second_idx;
  logic [CNT_W-1:0] best_cnt, second_cnt;
  logic             best_ok, second_ok;
  logic             first;
  logic [LEN_W-1:0] total;
  logic             too_long;

  logic             acc_in, letter_ok, out_free, over;
  logic             ld, ld_last, ld_fail;
  logic [LET_W-1:0] ld_letter;
  logic             b_ok, s_ok, hit;
  logic [CNT_W:0]   dbl_cnt;
  logic [LEN_W:0]   half_lim;

  lis_count_bank u_bank (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .rd_cnt (rd_cnt)
  );

  assign acc_in    = in_valid && !in_stall;
  assign letter_ok = letter < ALPHA_V;
  assign out_free  = !out_valid || !out_stall;

  // failure test on the first round: top count above half the length, rounded up
  assign dbl_cnt  = {best_cnt, 1'b0};
  assign half_lim = {1'b0, total} + (LEN_W+1)'(1);
  assign over     = dbl_cnt > half_lim;

  // shared compare unit inputs; flags read as clear at the start of a scan
  assign hit  = rd_cnt != '0;
  assign b_ok = best_ok && (idx != '0);
  assign s_ok = second_ok && (idx != '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:   if (acc_in && last) state_next = S_START;
      S_START:  state_next = too_long ? S_FAIL : S_SCAN;
      S_SCAN:   if (idx == LAST_CODE) state_next = S_DECIDE;
      S_DECIDE: begin
        if (!best_ok) begin
          state_next = S_CLEAR;
        end else if (first && over) begin
          state_next = S_FAIL;
        end else begin
          state_next = S_EMIT_A;
        end
      end
      S_EMIT_A: if (out_free) state_next = second_ok ? S_EMIT_B : S_CLEAR;
      S_EMIT_B: if (out_free) state_next = (total == LEN_W'(1)) ? S_CLEAR : S_SCAN;
      S_FAIL:   if (out_free) state_next = S_CLEAR;
      S_CLEAR:  state_next = S_LOAD;
      default:  state_next = S_LOAD;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall    = 1'b1;
    ctl         = '0;
    ctl.inc_idx = letter;
    ctl.dec_idx = best_idx;
    ctl.rd_idx  = idx;
    ld          = 1'b0;
    ld_letter   = '0;
    ld_last     = 1'b0;
    ld_fail     = 1'b0;
    case (state)
      S_LOAD: begin
        in_stall   = 1'b0;
        ctl.inc_en = in_valid && letter_ok && (total < MAX_LEN_V);
      end
      S_EMIT_A: begin
        ld         = out_free;
        ld_letter  = best_idx;
        ld_last    = !second_ok;
        ctl.dec_en = out_free;
      end
      S_EMIT_B: begin
        ld          = out_free;
        ld_letter   = second_idx;
        ld_last     = total == LEN_W'(1);
        ctl.dec_en  = out_free;
        ctl.dec_idx = second_idx;
      end
      S_FAIL: begin
        ld      = out_free;
        ld_last = 1'b1;
        ld_fail = 1'b1;
      end
      S_CLEAR:  ctl.clear = 1'b1;
      default: ;
    endcase
  end

  // control and scan registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      idx       <= '0;
      best_ok   <= 1'b0;
      second_ok <= 1'b0;
      first     <= 1'b0;
      total     <= '0;
      too_long  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= ld || (out_valid && out_stall);
      case (state)
        S_LOAD: begin
          if (acc_in && letter_ok) begin
            if (total >= MAX_LEN_V) begin
              too_long <= 1'b1;
            end else begin
              total <= total + LEN_W'(1);
            end
          end
        end
        S_START:  first <= 1'b1;
        S_SCAN: begin
          idx       <= (idx == LAST_CODE) ? '0 : idx + LET_W'(1);
          best_ok   <= b_ok;
          second_ok <= s_ok;
          if (hit) begin
            if (!b_ok || rd_cnt >= best_cnt) begin
              second_ok  <= b_ok;
              second_idx <= best_idx;
              second_cnt <= best_cnt;
              best_ok    <= 1'b1;
              best_idx   <= idx;
              best_cnt   <= rd_cnt;
            end else if (!s_ok || rd_cnt >= second_cnt) begin
              second_ok  <= 1'b1;
              second_idx <= idx;
              second_cnt <= rd_cnt;
            end
          end
        end
        S_DECIDE: first <= 1'b0;
        S_EMIT_A, S_EMIT_B: begin
          if (ctl.dec_en) total <= total - LEN_W'(1);
        end
        S_CLEAR: begin
          total    <= '0;
          too_long <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // output beat payload
  always_ff @(posedge clk) begin
    if (ld) begin
      out_letter <= ld_letter;
      out_last   <= ld_last;
      failed     <= ld_fail;
    end
  end

  // checks
  a_fail_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && failed |-> out_last && out_letter == '0)
    else $error("failure beat without last mark or with a letter");

  a_pair_has_second: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT_B |-> second_ok)
    else $error("second letter emitted without a valid second pick");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    total <= MAX_LEN_V)
    else $error("letter count above the maximum length");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD && $past(state == S_CLEAR) |-> total == '0 && !too_long)
    else $error("string state not cleared at end of string");

endmodule

`default_nettype wire
